[hw/rtl/hashed_lru_buffer_cache_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the hashed LRU buffer cache
// Immediate-implication and next-cycle checks on the top level clock.
// ----------------------------------------------------------------------------
`ifndef HASHED_LRU_BUFFER_CACHE_TOP_MACROS_SVH
`define HASHED_LRU_BUFFER_CACHE_TOP_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define HLBC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante
`define HLBC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/hlbc_pkg.sv]
// ----------------------------------------------------------------------------
// hlbc_pkg
// Shared types and constants of the hashed LRU buffer cache.
// ----------------------------------------------------------------------------
package hlbc_pkg;

    localparam int DEF_NUM_BUFFERS = 32;
    localparam int DEF_NUM_BUCKETS = 13;

    localparam int OP_W   = 2;
    localparam int DEV_W  = 8;
    localparam int BLK_W  = 32;
    localparam int IDX_W  = 5;
    localparam int CNT_W  = 8;
    localparam int STAT_W = 2;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_GET   = 2'd0,
        OP_REL   = 2'd1,
        OP_PIN   = 2'd2,
        OP_UNPIN = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_NOFREE = 2'd1,
        ST_UNDER  = 2'd2
    } t_status;

    typedef struct packed {
        t_op                operation;
        logic [DEV_W-1:0]   device_id;
        logic [BLK_W-1:0]   block_number;
        logic [IDX_W-1:0]   buffer_index;
    } t_in;

    typedef struct packed {
        logic [IDX_W-1:0]   granted_buffer;
        logic               needs_read;
        t_status            status;
    } t_out;

endpackage

[hw/rtl/hashed_lru_buffer_cache_top.sv]
// ----------------------------------------------------------------------------
// hashed_lru_buffer_cache_top
// Buffer tag pool kept in per-bucket doubly linked recency lists, held in a
// link memory and a tag memory and walked one node per cycle.
//
//   channel  | direction | handshake               | beat
//   command  | in        | start high, busy low    | i_cmd (t_in)
//   result   | out       | o_done, one cycle       | o_result (t_out)
//
// After reset the link and tag memories are swept, one node a cycle,
// with busy high.
// A get computes the bucket remainder after acceptance, then opens list heads
// and visits list nodes in the search walks; a move between lists also runs
// the detach and push states. Release, pin and unpin of an index in range
// update its tag count, not below zero; a release that zeroes it relinks it.
// The result beat follows the last work cycle; busy drops in that cycle.
// ----------------------------------------------------------------------------
`include "hashed_lru_buffer_cache_top_macros.svh"

module hashed_lru_buffer_cache_top #(
    parameter int NUM_BUFFERS = hlbc_pkg::DEF_NUM_BUFFERS,
    parameter int NUM_BUCKETS = hlbc_pkg::DEF_NUM_BUCKETS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  hlbc_pkg::t_in  i_cmd,
    output logic           busy,
    output logic           o_done,
    output hlbc_pkg::t_out o_result
);

    localparam int NB = NUM_BUFFERS;
    localparam int NN = NUM_BUFFERS + NUM_BUCKETS;
    localparam int NW = $clog2(NN);
    localparam int BW = $clog2(NB);
    localparam int KW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int SW = $clog2(NN + 1);
    localparam int IW = hlbc_pkg::IDX_W;
    localparam int CW = hlbc_pkg::CNT_W;

    typedef struct packed {
        logic [NW-1:0] fwd;
        logic [NW-1:0] bwd;
    } t_link;

    typedef struct packed {
        logic [CW-1:0]              cnt;
        logic                       val;
        logic [hlbc_pkg::DEV_W-1:0] dev;
        logic [hlbc_pkg::BLK_W-1:0] blk;
        logic [KW-1:0]              bkt;
    } t_tag;

    localparam int LW = $bits(t_link);
    localparam int TW = $bits(t_tag);

    typedef enum logic [18:0] {
        S_CLR  = 19'd1 << 0,
        S_IDLE = 19'd1 << 1,
        S_MOD  = 19'd1 << 2,
        S_HEAD = 19'd1 << 3,
        S_WALK = 19'd1 << 4,
        S_SCAN = 19'd1 << 5,
        S_TCHK = 19'd1 << 6,
        S_LNK  = 19'd1 << 7,
        S_D1   = 19'd1 << 8,
        S_D2   = 19'd1 << 9,
        S_D3   = 19'd1 << 10,
        S_D4   = 19'd1 << 11,
        S_P1   = 19'd1 << 12,
        S_P2   = 19'd1 << 13,
        S_P3   = 19'd1 << 14,
        S_P4   = 19'd1 << 15,
        S_P5   = 19'd1 << 16,
        S_RSV0 = 19'd1 << 17,
        S_RSV1 = 19'd1 << 18
    } t_state;

    typedef enum logic [1:0] {
        WK_FIND  = 2'd0,
        WK_OWN   = 2'd1,
        WK_OTHER = 2'd2
    } t_walk;

    t_state         r_state, n_state;
    hlbc_pkg::t_in  r_cmd, n_cmd;
    t_walk          r_mode, n_mode;
    logic [NW-1:0]  r_head, n_head;
    logic [NW-1:0]  r_whead, n_whead;
    logic [NW-1:0]  r_node, n_node;
    logic [SW-1:0]  r_steps, n_steps;
    logic [NW-1:0]  r_k, n_k;
    logic [NW-1:0]  r_b, n_b;
    logic [NW-1:0]  r_bf, n_bf;
    logic [NW-1:0]  r_bb, n_bb;
    logic [NW-1:0]  r_first, n_first;
    logic [KW-1:0]  r_bkt, n_bkt;
    logic [NW-1:0]  r_clr, n_clr;
    logic           r_out_vld, n_out_vld;
    hlbc_pkg::t_out r_out, n_out;

    logic          l_we, t_we;
    logic [NW-1:0] l_wa, l_ra;
    logic [BW-1:0] t_wa, t_ra;
    t_link         l_wd, lk_rd, clr_link;
    t_tag          t_wd, tg_rd, new_tag;
    logic [LW-1:0] lk_raw;
    logic [TW-1:0] tg_raw;

    logic          mod_start, mod_done;
    logic [KW-1:0] mod_rem;

    logic [NW-1:0] w_next;
    logic [SW-1:0] w_steps1;
    logic          w_match, w_found, w_fail, w_last_k;

    // link memory: one node per buffer and per bucket head
    hlbc_ram #(.WIDTH(LW), .DEPTH(NN)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_wa),
        .i_wdata (l_wd),
        .i_raddr (l_ra),
        .o_rdata (lk_raw)
    );

    // tag memory: count, valid bit, tag and bucket per buffer
    hlbc_ram #(.WIDTH(TW), .DEPTH(NB)) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (t_wa),
        .i_wdata (t_wd),
        .i_raddr (t_ra),
        .o_rdata (tg_raw)
    );

    // bucket of the requested block, taken from the accepted beat
    hlbc_mod #(.NUM_BUCKETS(NUM_BUCKETS), .KW(KW)) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_value (n_cmd.block_number),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    assign lk_rd = t_link'(lk_raw);
    assign tg_rd = t_tag'(tg_raw);

    // reset image: bucket zero holds every buffer, buffer 0 least recent
    always_comb begin
        clr_link.fwd = r_clr;
        clr_link.bwd = r_clr;
        if (r_clr < NW'(NB)) begin
            clr_link.fwd = (r_clr == '0) ? NW'(NB) : r_clr - 1'b1;
            clr_link.bwd = (r_clr == NW'(NB - 1)) ? NW'(NB) : r_clr + 1'b1;
        end else if (r_clr == NW'(NB)) begin
            clr_link.fwd = NW'(NB - 1);
            clr_link.bwd = '0;
        end
    end

    // walk helpers
    assign w_next   = (r_mode == WK_FIND) ? lk_rd.fwd : lk_rd.bwd;
    assign w_steps1 = r_steps + 1'b1;
    assign w_match  = (r_mode == WK_FIND) ?
                      (tg_rd.dev == r_cmd.device_id && tg_rd.blk == r_cmd.block_number) :
                      (tg_rd.cnt == '0);
    assign w_last_k = (r_k == NW'(NN - 1));

    always_comb begin
        new_tag.cnt = CW'(1);
        new_tag.val = 1'b1;
        new_tag.dev = r_cmd.device_id;
        new_tag.blk = r_cmd.block_number;
        new_tag.bkt = r_bkt;
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_mode    = r_mode;
        n_head    = r_head;
        n_whead   = r_whead;
        n_node    = r_node;
        n_steps   = r_steps;
        n_k       = r_k;
        n_b       = r_b;
        n_bf      = r_bf;
        n_bb      = r_bb;
        n_first   = r_first;
        n_bkt     = r_bkt;
        n_clr     = r_clr;
        n_out_vld = 1'b0;
        n_out     = r_out;
        l_we      = 1'b0;
        l_wa      = r_node;
        l_wd      = lk_rd;
        l_ra      = r_node;
        t_we      = 1'b0;
        t_wa      = r_node[BW-1:0];
        t_wd      = tg_rd;
        t_ra      = r_node[BW-1:0];
        mod_start = 1'b0;
        w_found   = 1'b0;
        w_fail    = 1'b0;

        case (r_state)
            S_CLR: begin
                l_we  = 1'b1;
                l_wa  = r_clr;
                l_wd  = clr_link;
                t_we  = (r_clr < NW'(NB));
                t_wa  = r_clr[BW-1:0];
                t_wd  = '0;
                n_clr = r_clr + 1'b1;
                if (r_clr == NW'(NN - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_cmd = i_cmd;
                    if (i_cmd.operation == hlbc_pkg::OP_GET) begin
                        mod_start = 1'b1;
                        n_state   = S_MOD;
                    end else if (32'(i_cmd.buffer_index) >= NB) begin
                        n_out_vld = 1'b1;
                        n_out     = '{i_cmd.buffer_index, 1'b0, hlbc_pkg::ST_OK};
                    end else begin
                        t_ra    = BW'(i_cmd.buffer_index);
                        n_state = S_TCHK;
                    end
                end
            end
            S_MOD: begin
                if (mod_done) begin
                    n_bkt   = mod_rem;
                    n_head  = NW'(NB) + NW'(mod_rem);
                    n_whead = NW'(NB) + NW'(mod_rem);
                    l_ra    = NW'(NB) + NW'(mod_rem);
                    n_mode  = WK_FIND;
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                if (w_next == r_whead || w_next >= NW'(NB)) begin
                    w_fail = 1'b1;
                end else begin
                    l_ra    = w_next;
                    t_ra    = w_next[BW-1:0];
                    n_node  = w_next;
                    n_steps = '0;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (w_match) begin
                    w_found = 1'b1;
                end else if (w_next == r_whead || w_next >= NW'(NB) ||
                             w_steps1 >= SW'(NN)) begin
                    w_fail = 1'b1;
                end else begin
                    l_ra    = w_next;
                    t_ra    = w_next[BW-1:0];
                    n_node  = w_next;
                    n_steps = w_steps1;
                end
            end
            S_SCAN: begin
                if (r_k == r_head) begin
                    if (w_last_k) begin
                        n_out_vld = 1'b1;
                        n_out     = '{'0, 1'b0, hlbc_pkg::ST_NOFREE};
                        n_state   = S_IDLE;
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end else begin
                    l_ra    = r_k;
                    n_whead = r_k;
                    n_mode  = WK_OTHER;
                    n_state = S_HEAD;
                end
            end
            S_TCHK: begin
                t_wa = BW'(r_cmd.buffer_index);
                if (r_cmd.operation == hlbc_pkg::OP_PIN) begin
                    t_we      = 1'b1;
                    t_wd.cnt  = (tg_rd.cnt == hlbc_pkg::CNT_MAX) ? tg_rd.cnt
                                                                 : tg_rd.cnt + 1'b1;
                    n_out_vld = 1'b1;
                    n_out     = '{r_cmd.buffer_index, 1'b0, hlbc_pkg::ST_OK};
                    n_state   = S_IDLE;
                end else if (tg_rd.cnt == '0) begin
                    n_out_vld = 1'b1;
                    n_out     = '{r_cmd.buffer_index, 1'b0, hlbc_pkg::ST_UNDER};
                    n_state   = S_IDLE;
                end else begin
                    t_we     = 1'b1;
                    t_wd.cnt = tg_rd.cnt - 1'b1;
                    if (r_cmd.operation == hlbc_pkg::OP_REL && tg_rd.cnt == CW'(1)) begin
                        n_b     = NW'(r_cmd.buffer_index);
                        n_head  = NW'(NB) + NW'(tg_rd.bkt);
                        l_ra    = NW'(r_cmd.buffer_index);
                        n_state = S_LNK;
                    end else begin
                        n_out_vld = 1'b1;
                        n_out     = '{r_cmd.buffer_index, 1'b0, hlbc_pkg::ST_OK};
                        n_state   = S_IDLE;
                    end
                end
            end
            S_LNK: begin
                n_bf    = lk_rd.fwd;
                n_bb    = lk_rd.bwd;
                n_state = S_D1;
            end
            // detach: fix the back link of the successor
            S_D1: begin
                l_ra    = r_bf;
                n_state = S_D2;
            end
            S_D2: begin
                l_we    = 1'b1;
                l_wa    = r_bf;
                l_wd    = '{lk_rd.fwd, r_bb};
                n_state = S_D3;
            end
            // detach: fix the forward link of the predecessor
            S_D3: begin
                l_ra    = r_bb;
                n_state = S_D4;
            end
            S_D4: begin
                l_we    = 1'b1;
                l_wa    = r_bb;
                l_wd    = '{r_bf, lk_rd.bwd};
                n_state = S_P1;
            end
            // push to the front of the target bucket
            S_P1: begin
                l_ra    = r_head;
                n_state = S_P2;
            end
            S_P2: begin
                n_first = lk_rd.fwd;
                l_we    = 1'b1;
                l_wa    = r_head;
                l_wd    = '{r_b, lk_rd.bwd};
                n_state = S_P3;
            end
            S_P3: begin
                l_we = 1'b1;
                l_wa = r_b;
                l_wd = '{r_first, r_head};
                if (r_cmd.operation == hlbc_pkg::OP_GET) begin
                    t_we = 1'b1;
                    t_wa = r_b[BW-1:0];
                    t_wd = new_tag;
                end
                n_state = S_P4;
            end
            S_P4: begin
                l_ra    = r_first;
                n_state = S_P5;
            end
            S_P5: begin
                l_we      = 1'b1;
                l_wa      = r_first;
                l_wd      = '{lk_rd.fwd, r_b};
                n_out_vld = 1'b1;
                if (r_cmd.operation == hlbc_pkg::OP_GET) begin
                    n_out = '{IW'(r_b), 1'b1, hlbc_pkg::ST_OK};
                end else begin
                    n_out = '{r_cmd.buffer_index, 1'b0, hlbc_pkg::ST_OK};
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // walk ended on a matching node
        if (w_found) begin
            n_b  = r_node;
            n_bf = lk_rd.fwd;
            n_bb = lk_rd.bwd;
            case (r_mode)
                WK_FIND: begin
                    t_we      = 1'b1;
                    t_wa      = r_node[BW-1:0];
                    t_wd      = tg_rd;
                    t_wd.cnt  = (tg_rd.cnt == hlbc_pkg::CNT_MAX) ? tg_rd.cnt
                                                                 : tg_rd.cnt + 1'b1;
                    t_wd.val  = 1'b1;
                    n_out_vld = 1'b1;
                    n_out     = '{IW'(r_node), !tg_rd.val, hlbc_pkg::ST_OK};
                    n_state   = S_IDLE;
                end
                WK_OWN: begin
                    t_we      = 1'b1;
                    t_wa      = r_node[BW-1:0];
                    t_wd      = new_tag;
                    n_out_vld = 1'b1;
                    n_out     = '{IW'(r_node), 1'b1, hlbc_pkg::ST_OK};
                    n_state   = S_IDLE;
                end
                default: begin
                    n_state = S_D1;
                end
            endcase
        end

        // walk ran off its list
        if (w_fail) begin
            case (r_mode)
                WK_FIND: begin
                    l_ra    = r_head;
                    n_whead = r_head;
                    n_mode  = WK_OWN;
                    n_state = S_HEAD;
                end
                WK_OWN: begin
                    n_k     = NW'(NB);
                    n_state = S_SCAN;
                end
                default: begin
                    if (w_last_k) begin
                        n_out_vld = 1'b1;
                        n_out     = '{'0, 1'b0, hlbc_pkg::ST_NOFREE};
                        n_state   = S_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_SCAN;
                    end
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_out_vld <= n_out_vld;
        end
    end

    // payload and walk registers
    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_mode  <= n_mode;
        r_head  <= n_head;
        r_whead <= n_whead;
        r_node  <= n_node;
        r_steps <= n_steps;
        r_k     <= n_k;
        r_b     <= n_b;
        r_bf    <= n_bf;
        r_bb    <= n_bb;
        r_first <= n_first;
        r_bkt   <= n_bkt;
        r_out   <= n_out;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_out_vld;
    assign o_result = r_out;

    `HLBC_ASSERT_NEXT(a_get_starts_mod, start && !busy && i_cmd.operation == hlbc_pkg::OP_GET, r_state == S_MOD, "get did not enter bucket computation")
    `HLBC_ASSERT_NOW(a_walk_bounded, r_state == S_WALK, r_steps < SW'(NN), "list walk exceeded node count")
    `HLBC_ASSERT_NOW(a_nofree_zero, o_done && o_result.status == hlbc_pkg::ST_NOFREE, o_result.granted_buffer == '0 && !o_result.needs_read, "empty pool result not cleared")
    `HLBC_ASSERT_NOW(a_read_ok, o_done && o_result.needs_read, o_result.status == hlbc_pkg::ST_OK, "read request on a failed beat")

endmodule

[hw/rtl/hlbc_ram.sv]
// ----------------------------------------------------------------------------
// hlbc_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module hlbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write one entry, read one entry, read data registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/hlbc_mod.sv]
// ----------------------------------------------------------------------------
// hlbc_mod
// Registered remainder of a block number by the bucket count.
// ----------------------------------------------------------------------------
module hlbc_mod #(
    parameter int NUM_BUCKETS = hlbc_pkg::DEF_NUM_BUCKETS,
    parameter int KW          = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [hlbc_pkg::BLK_W-1:0] i_value,
    output logic                       o_done,
    output logic [KW-1:0]              o_rem
);

    // folded sum of the four bytes stays below 2^15 for up to 31 buckets
    localparam int SUM_W = 15;
    localparam int SH    = 20;
    localparam int PW    = SUM_W + SH;

    // byte weights 2^(8i) mod the bucket count
    localparam logic [SUM_W-1:0] C1  = SUM_W'((1 << 8) % NUM_BUCKETS);
    localparam logic [SUM_W-1:0] C2  = SUM_W'((1 << 16) % NUM_BUCKETS);
    localparam logic [SUM_W-1:0] C3  = SUM_W'((1 << 24) % NUM_BUCKETS);
    localparam logic [SUM_W-1:0] DIV = SUM_W'(NUM_BUCKETS);
    // rounded-up reciprocal, exact quotient for every folded sum
    localparam logic [SH:0] RECIP = (SH+1)'(((1 << SH) + NUM_BUCKETS - 1) / NUM_BUCKETS);

    logic             r_sum_vld;
    logic             r_done;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [KW-1:0]    r_rem, n_rem;
    logic [PW-1:0]    w_prod;
    logic [SUM_W-1:0] w_quo;
    logic [SUM_W-1:0] w_back;

    // fold the bytes, then reduce the sum by reciprocal multiplication
    always_comb begin
        n_sum  = SUM_W'(i_value[7:0])
               + SUM_W'(i_value[15:8]) * C1
               + SUM_W'(i_value[23:16]) * C2
               + SUM_W'(i_value[31:24]) * C3;
        w_prod = PW'(r_sum) * PW'(RECIP);
        w_quo  = w_prod[PW-1:SH];
        w_back = r_sum - w_quo * DIV;
        n_rem  = KW'(w_back);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_vld <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_sum_vld <= i_start;
            r_done    <= r_sum_vld;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
